### sv/vtr_pkg.sv
// shared types, constants and selection tables for the voigt tensor rotation block
// no dependencies
`default_nettype none
package vtr_pkg;

    localparam int CW    = 32;          // component width
    localparam int AW    = 16;          // q1.14 matrix entry width
    localparam int PW    = 2 * AW + 1;  // doubled entry product
    localparam int MW    = PW + CW;     // full term product
    localparam int FRAC  = 28;
    localparam int TW    = MW - FRAC;   // term after the shift
    localparam int GW    = TW + 2;      // sum of three terms
    localparam int SW    = GW + 2;      // sum of three groups
    localparam int NL    = 9;           // lanes, one per result component
    localparam int NS    = 9;           // term slots per lane
    localparam int NG    = 3;           // partial sum groups per lane
    localparam int DW    = 48;          // configuration word width
    localparam int IW    = 3;           // configuration index width
    localparam int XW    = 4;           // index into nine entries

    localparam logic [2:0] OP_STRAIN_FWD = 3'd0;
    localparam logic [2:0] OP_STRAIN_BWD = 3'd1;
    localparam logic [2:0] OP_STRESS_FWD = 3'd2;
    localparam logic [2:0] OP_STRESS_BWD = 3'd3;
    localparam logic [2:0] OP_GRAD_FWD   = 3'd4;
    localparam logic [2:0] OP_GRAD_BWD   = 3'd5;

    localparam logic [IW-1:0] REG_ORIENT_FIRST  = 3'd0;
    localparam logic [IW-1:0] REG_ORIENT_SECOND = 3'd1;
    localparam logic [IW-1:0] REG_ROT_A         = 3'd2;
    localparam logic [IW-1:0] REG_ROT_B         = 3'd3;
    localparam logic [IW-1:0] REG_ROT_C         = 3'd4;

    typedef logic signed [AW-1:0] q14_t;
    typedef q14_t                 mat_t [NL];
    typedef logic signed [CW-1:0] comp_t;
    typedef comp_t                comp_vec_t [NL];
    typedef logic signed [GW-1:0] grp_t;
    typedef grp_t                 grp_vec_t [NG];
    typedef grp_t                 grp_mat_t [NL][NG];

    typedef enum logic [1:0] {KIND_STRAIN, KIND_STRESS, KIND_GRAD, KIND_NONE} kind_t;

    typedef struct packed {
        logic          en;
        logic          dbl;
        logic [XW-1:0] ea;
        logic [XW-1:0] eb;
        logic [XW-1:0] ci;
    } term_sel_t;

    // voigt order xx yy zz xy xz yz, padded to nine entries
    localparam int VROW [NL] = '{0, 1, 2, 0, 0, 1, 0, 0, 0};
    localparam int VCOL [NL] = '{0, 1, 2, 1, 2, 2, 0, 0, 0};
    localparam int ROW3 [NL] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    localparam int COL3 [NL] = '{0, 1, 2, 0, 1, 2, 0, 1, 2};
    localparam int TRN  [NL] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};
    // mixed shear inputs take two slots each
    localparam int MIXM [NS] = '{0, 0, 0, 3, 3, 4, 4, 5, 5};
    localparam int MIXH [NS] = '{0, 0, 0, 0, 1, 0, 1, 0, 1};

    function automatic kind_t op_kind(input logic [2:0] op);
        kind_t k;
        unique case (op)
            OP_STRAIN_FWD, OP_STRAIN_BWD: k = KIND_STRAIN;
            OP_STRESS_FWD, OP_STRESS_BWD: k = KIND_STRESS;
            OP_GRAD_FWD, OP_GRAD_BWD:     k = KIND_GRAD;
            default:                      k = KIND_NONE;
        endcase
        return k;
    endfunction

    // which entries, component and factor feed one slot of one lane
    function automatic term_sel_t term_sel(input kind_t kind, input logic [XW-1:0] lane,
                                           input logic [XW-1:0] slot);
        term_sel_t s;
        int p, q, i, j, m;
        s = '0;
        if (kind == KIND_GRAD) begin
            s.en = 1'b1;
            s.ea = XW'(3 * ROW3[lane] + ROW3[slot]);
            s.eb = XW'(3 * COL3[lane] + COL3[slot]);
            s.ci = slot;
        end
        else if (kind != KIND_NONE && lane < XW'(6)) begin
            p = VROW[lane];
            q = VCOL[lane];
            if (p == q) begin
                if (slot < XW'(6)) begin
                    i     = VROW[slot];
                    j     = VCOL[slot];
                    s.en  = 1'b1;
                    s.dbl = (i != j) && (kind == KIND_STRESS);
                    s.ea  = XW'(3 * p + i);
                    s.eb  = XW'(3 * p + j);
                    s.ci  = slot;
                end
            end
            else if (slot < XW'(3)) begin
                s.en  = 1'b1;
                s.dbl = (kind == KIND_STRAIN);
                s.ea  = XW'(3 * p) + slot;
                s.eb  = XW'(3 * q) + slot;
                s.ci  = slot;
            end
            else begin
                m    = MIXM[slot];
                i    = VROW[XW'(m)];
                j    = VCOL[XW'(m)];
                s.en = 1'b1;
                s.ea = XW'(3 * p + ((MIXH[slot] != 0) ? j : i));
                s.eb = XW'(3 * q + ((MIXH[slot] != 0) ? i : j));
                s.ci = XW'(m);
            end
        end
        return s;
    endfunction

    function automatic logic [XW-1:0] transpose_idx(input logic [XW-1:0] e);
        return XW'(TRN[e]);
    endfunction

endpackage
`default_nettype wire

### sv/voigt_tensor_rotation_3d.sv
// top level of the voigt tensor rotation block
// depends on vtr_pkg, vtr_orient, vtr_lane, vtr_merge
`default_nettype none
// Rotates one tensor word per clock while busy is low. An item is taken on any edge with
// start high and busy low; its result words appear on res0..res8 with done high for one
// cycle, after the registered stages of select and entry products, component products,
// partial sums and final sum with saturation. Nine lanes, one per result component, each
// hold nine term slots, so a new word may enter every cycle that busy is low, regardless
// of earlier ones. busy is high only after a configuration write (and after reset) while
// the orientation matrix is rebuilt: direction rows first, then their cross product.
// cfg_ready is always high; writes to indexes past the register list are dropped.
module voigt_tensor_rotation_3d (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [2:0]                   operation,
    input  wire logic signed [vtr_pkg::CW-1:0] comp0,
    input  wire logic signed [vtr_pkg::CW-1:0] comp1,
    input  wire logic signed [vtr_pkg::CW-1:0] comp2,
    input  wire logic signed [vtr_pkg::CW-1:0] comp3,
    input  wire logic signed [vtr_pkg::CW-1:0] comp4,
    input  wire logic signed [vtr_pkg::CW-1:0] comp5,
    input  wire logic signed [vtr_pkg::CW-1:0] comp6,
    input  wire logic signed [vtr_pkg::CW-1:0] comp7,
    input  wire logic signed [vtr_pkg::CW-1:0] comp8,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [vtr_pkg::IW-1:0]       cfg_index,
    input  wire logic [vtr_pkg::DW-1:0]       cfg_data,
    output logic                              done,
    output logic signed [vtr_pkg::CW-1:0]     res0,
    output logic signed [vtr_pkg::CW-1:0]     res1,
    output logic signed [vtr_pkg::CW-1:0]     res2,
    output logic signed [vtr_pkg::CW-1:0]     res3,
    output logic signed [vtr_pkg::CW-1:0]     res4,
    output logic signed [vtr_pkg::CW-1:0]     res5,
    output logic signed [vtr_pkg::CW-1:0]     res6,
    output logic signed [vtr_pkg::CW-1:0]     res7,
    output logic signed [vtr_pkg::CW-1:0]     res8
);
    import vtr_pkg::*;

    comp_vec_t comps;
    comp_vec_t res;
    mat_t      mat;
    grp_mat_t  grp_all;
    logic      accept;
    logic [2:0] vld_reg;   // word in flight after select, multiply, partial sum stages

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // gather the component ports
    assign comps = '{comp0, comp1, comp2, comp3, comp4, comp5, comp6, comp7, comp8};

    vtr_orient u_orient (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .mat       (mat)
    );

    // one lane per result component
    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        vtr_lane u_lane (
            .clk       (clk),
            .lane_id   (XW'(l)),
            .operation (operation),
            .comps     (comps),
            .mat       (mat),
            .grp       (grp_all[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[1:0], accept};
    end

    vtr_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld_reg[2]),
        .grp_all  (grp_all),
        .done     (done),
        .res      (res)
    );

    assign res0 = res[0];
    assign res1 = res[1];
    assign res2 = res[2];
    assign res3 = res[3];
    assign res4 = res[4];
    assign res5 = res[5];
    assign res6 = res[6];
    assign res7 = res[7];
    assign res8 = res[8];

`ifndef ASSERT_OFF
    // every result word traces back to an earlier accepted word
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result word without matching input word");

    // a matrix rebuild holds off new words
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> busy)
        else $error("not busy after configuration write");

    // symmetric modes leave the upper three result words at zero
    a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation <= OP_STRESS_BWD) |-> ##4
        (res6 == '0 && res7 == '0 && res8 == '0))
        else $error("symmetric mode result has nonzero upper words");
`endif

endmodule
`default_nettype wire

### sv/vtr_orient.sv
// configuration registers and orientation matrix builder
// depends on vtr_pkg
`default_nettype none
module vtr_orient (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [vtr_pkg::IW-1:0] cfg_index,
    input  wire logic [vtr_pkg::DW-1:0] cfg_data,
    output logic                       busy,
    output vtr_pkg::mat_t              mat
);
    import vtr_pkg::*;

    logic [DW-1:0] regs_reg [5];
    logic [1:0]    pend_reg;
    q14_t          row01_reg [6];
    q14_t          row01_next [6];
    q14_t          row2_reg [3];
    q14_t          row2_next [3];

    function automatic q14_t field(input logic [DW-1:0] w, input int k);
        return q14_t'(w[16*k +: 16]);
    endfunction

    function automatic q14_t sat_shift(input logic signed [AW*2+1:0] s);
        logic signed [AW*2+1:0] f;
        f = s >>> 14;
        if (&f[AW*2+1:AW-1] || ~|f[AW*2+1:AW-1])
            return f[AW-1:0];
        return f[AW*2+1] ? q14_t'({1'b1, {(AW-1){1'b0}}}) : q14_t'({1'b0, {(AW-1){1'b1}}});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[0] <= DW'(48'd16384);
            regs_reg[1] <= DW'(48'd1073741824);
            regs_reg[2] <= DW'(48'd16384);
            regs_reg[3] <= DW'(48'd1073741824);
            regs_reg[4] <= DW'(48'd70368744177664);
            pend_reg    <= 2'd2;
        end
        else
        begin
            if (cfg_write)
            begin
                pend_reg <= 2'd2;
                if (cfg_index <= REG_ROT_C)
                    regs_reg[cfg_index] <= cfg_data;
            end
            else if (pend_reg != 2'd0)
                pend_reg <= pend_reg - 2'd1;
        end
    end

    // rows 0 and 1: rotation increment times each direction
    always_comb
    begin
        logic signed [AW*2-1:0] pr0, pr1;
        logic signed [AW*2+1:0] s0, s1;
        for (int r = 0; r < 3; r++)
        begin
            s0 = '0;
            s1 = '0;
            for (int c = 0; c < 3; c++)
            begin
                pr0 = field(regs_reg[2+c], r) * field(regs_reg[REG_ORIENT_FIRST], c);
                pr1 = field(regs_reg[2+c], r) * field(regs_reg[REG_ORIENT_SECOND], c);
                s0  = s0 + (AW*2+2)'(pr0);
                s1  = s1 + (AW*2+2)'(pr1);
            end
            row01_next[r]   = sat_shift(s0);
            row01_next[3+r] = sat_shift(s1);
        end
    end

    // row 2: cross product of the registered rows
    always_comb
    begin
        logic signed [AW*2-1:0] pa, pb;
        for (int r = 0; r < 3; r++)
        begin
            pa = row01_reg[(r+1)%3] * row01_reg[3+(r+2)%3];
            pb = row01_reg[3+(r+1)%3] * row01_reg[(r+2)%3];
            row2_next[r] = sat_shift((AW*2+2)'(pa) - (AW*2+2)'(pb));
        end
    end

    always_ff @(posedge clk)
    begin
        row01_reg <= row01_next;
        row2_reg  <= row2_next;
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            mat[k] = row01_reg[k];
        for (int k = 0; k < 3; k++)
            mat[6+k] = row2_reg[k];
    end

    assign busy = (pend_reg != 2'd0);

endmodule
`default_nettype wire

### sv/vtr_lane.sv
// one result lane: term select, two multiplies, partial sums
// depends on vtr_pkg
`default_nettype none
module vtr_lane (
    input  wire logic                  clk,
    input  wire logic [vtr_pkg::XW-1:0] lane_id,
    input  wire logic [2:0]            operation,
    input  wire vtr_pkg::comp_vec_t    comps,
    input  wire vtr_pkg::mat_t         mat,
    output vtr_pkg::grp_vec_t          grp
);
    import vtr_pkg::*;

    logic signed [PW-1:0] p_reg [NS];
    logic signed [PW-1:0] p_next [NS];
    comp_t                c_reg [NS];
    comp_t                c_next [NS];
    logic signed [MW-1:0] m_reg [NS];
    grp_t                 grp_reg [NG];
    grp_t                 grp_next [NG];

    always_comb
    begin
        term_sel_t              s;
        logic [XW-1:0]          ea, eb;
        logic signed [AW*2-1:0] pp;
        for (int t = 0; t < NS; t++)
        begin
            s  = term_sel(op_kind(operation), lane_id, XW'(t));
            ea = operation[0] ? transpose_idx(s.ea) : s.ea;
            eb = operation[0] ? transpose_idx(s.eb) : s.eb;
            pp = mat[ea] * mat[eb];
            if (!s.en)
                p_next[t] = '0;
            else if (s.dbl)
                p_next[t] = {pp, 1'b0};
            else
                p_next[t] = PW'(pp);
            c_next[t] = comps[s.ci];
        end
    end

    // floor shift of each term, then sums of three
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < 3; k++)
                grp_next[g] = grp_next[g] + GW'(m_reg[3*g+k] >>> FRAC);
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        c_reg   <= c_next;
        for (int t = 0; t < NS; t++)
            m_reg[t] <= MW'(p_reg[t]) * MW'(c_reg[t]);
        grp_reg <= grp_next;
    end

    assign grp = grp_reg;

endmodule
`default_nettype wire

### sv/vtr_merge.sv
// final sum of each lane, saturation and result strobe
// depends on vtr_pkg
`default_nettype none
module vtr_merge (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire vtr_pkg::grp_mat_t grp_all,
    output logic                   done,
    output vtr_pkg::comp_vec_t     res
);
    import vtr_pkg::*;

    logic      done_reg;
    comp_t     res_reg [NL];
    comp_t     res_next [NL];

    always_comb
    begin
        logic signed [SW-1:0] tot;
        for (int l = 0; l < NL; l++)
        begin
            tot = SW'(grp_all[l][0]) + SW'(grp_all[l][1]) + SW'(grp_all[l][2]);
            if (&tot[SW-1:CW-1] || ~|tot[SW-1:CW-1])
                res_next[l] = tot[CW-1:0];
            else
                res_next[l] = tot[SW-1] ? comp_t'({1'b1, {(CW-1){1'b0}}})
                                        : comp_t'({1'b0, {(CW-1){1'b1}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire
